### src/sorted_wakeup_timer_queue_macros.svh
// Assertion macros for the sorted wakeup timer queue.
`ifndef SORTED_WAKEUP_TIMER_QUEUE_MACROS_SVH
`define SORTED_WAKEUP_TIMER_QUEUE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SWTQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SWTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

### src/swtq_pkg.sv
// Package for the sorted wakeup timer queue: sizes, status codes and states.
package swtq_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_WOKEN    = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  localparam logic FUNC_SLEEP = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRD,
    S_SCHK,
    S_TRD,
    S_TCHK,
    S_CRD,
    S_CWR
  } state_t;
endpackage

### src/sorted_wakeup_timer_queue.sv
// Sorted wakeup timer queue: top level with queue memory and sequencer.
// A sleep request or a tick is taken when start is high and busy is low;
// results appear for one cycle each with strobe high and cannot be held off.
// The queue sits in one single-port memory (one read or write per cycle,
// read data registered into the next cycle), so every item is a walk over that memory.
// A sleep moves entries up one slot from the tail to open the slot, a read
// and a write per entry; a tick examines entries from the front and then
// compacts the surviving entries to the front. A woken result is
// held back until the next entry has been examined, so that last is known.
// A queue-full reply does not raise busy (its result is registered and
// appears in the next cycle); a tick on an empty queue goes straight from
// S_TRD back to idle.
`include "sorted_wakeup_timer_queue_macros.svh"
module sorted_wakeup_timer_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [7:0]  sleeper_id,
  input  logic [31:0] duration,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [7:0]  woken_id,
  output logic [63:0] tick_count,
  output logic        last
);
  localparam int IW = swtq_pkg::IDX_W;
  localparam int CW = swtq_pkg::CNT_W;

  // queue memory: wake time and sleeper id per entry
  logic [71:0] mem [swtq_pkg::QUEUE_DEPTH];
  logic [71:0] rdata;
  logic        mwe, mre;
  logic [IW-1:0] maddr;
  logic [71:0] mwdata;

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwdata;
    if (mre) rdata <= mem[maddr];
  end

  swtq_pkg::state_t state, state_next;
  logic [63:0] tick_counter, tick_counter_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [CW-1:0] ptr, ptr_next;      // walking index
  logic [CW-1:0] woken, woken_next;  // entries popped this tick
  logic [63:0] wake, wake_next;
  logic [7:0]  sid, sid_next;
  logic [7:0]  pend_id, pend_id_next; // woken id waiting for its last flag
  logic        strobe_next, last_next;
  logic [1:0]  status_next;
  logic [7:0]  woken_id_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swtq_pkg::S_IDLE;
      tick_counter <= '0;
      entry_count <= '0;
      strobe <= 1'b0;
    end else begin
      state <= state_next;
      tick_counter <= tick_counter_next;
      entry_count <= entry_count_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    woken <= woken_next;
    wake <= wake_next;
    sid <= sid_next;
    pend_id <= pend_id_next;
    status <= status_next;
    woken_id <= woken_id_next;
    last <= last_next;
  end

  assign tick_count = tick_counter;
  assign busy = (state != swtq_pkg::S_IDLE);

  // sequencer: insertion shifts from the tail down; a tick pops then compacts
  always_comb begin
    state_next = state;
    tick_counter_next = tick_counter;
    entry_count_next = entry_count;
    ptr_next = ptr;
    woken_next = woken;
    wake_next = wake;
    sid_next = sid;
    pend_id_next = pend_id;
    strobe_next = 1'b0;
    status_next = status;
    woken_id_next = woken_id;
    last_next = last;
    mwe = 1'b0;
    mre = 1'b0;
    maddr = '0;
    mwdata = {wake, sid};
    unique case (state)
      swtq_pkg::S_IDLE: begin
        if (start) begin
          if (func == swtq_pkg::FUNC_SLEEP) begin
            if (entry_count == CW'(swtq_pkg::QUEUE_DEPTH)) begin
              strobe_next = 1'b1;
              status_next = swtq_pkg::ST_FULL;
              woken_id_next = '0;
              last_next = 1'b1;
            end else begin
              wake_next = tick_counter + {32'd0, duration};
              sid_next = sleeper_id;
              ptr_next = entry_count;
              state_next = swtq_pkg::S_SRD;
            end
          end else begin
            tick_counter_next = tick_counter + 64'd1;
            woken_next = '0;
            ptr_next = '0;
            state_next = swtq_pkg::S_TRD;
          end
        end
      end
      // sleep: ptr is the free slot; look at the entry just before it
      swtq_pkg::S_SRD: begin
        if (ptr == '0) begin
          mwe = 1'b1;
          maddr = '0;
          entry_count_next = entry_count + CW'(1);
          strobe_next = 1'b1;
          status_next = swtq_pkg::ST_ACCEPTED;
          woken_id_next = '0;
          last_next = 1'b1;
          state_next = swtq_pkg::S_IDLE;
        end else begin
          mre = 1'b1;
          maddr = IW'(ptr - CW'(1));
          state_next = swtq_pkg::S_SCHK;
        end
      end
      swtq_pkg::S_SCHK: begin
        maddr = IW'(ptr);
        if (rdata[71:8] <= wake) begin
          mwe = 1'b1;
          entry_count_next = entry_count + CW'(1);
          strobe_next = 1'b1;
          status_next = swtq_pkg::ST_ACCEPTED;
          woken_id_next = '0;
          last_next = 1'b1;
          state_next = swtq_pkg::S_IDLE;
        end else begin
          mwe = 1'b1;
          mwdata = rdata;
          ptr_next = ptr - CW'(1);
          state_next = swtq_pkg::S_SRD;
        end
      end
      // tick: examine entry at ptr; at the end flush the held result
      swtq_pkg::S_TRD: begin
        if (ptr == entry_count) begin
          ptr_next = woken;
          strobe_next = 1'b1;
          last_next = 1'b1;
          if (woken == '0) begin
            status_next = swtq_pkg::ST_NONE;
            woken_id_next = '0;
            state_next = swtq_pkg::S_IDLE;
          end else begin
            status_next = swtq_pkg::ST_WOKEN;
            woken_id_next = pend_id;
            state_next = swtq_pkg::S_CRD;
          end
        end else begin
          mre = 1'b1;
          maddr = IW'(ptr);
          state_next = swtq_pkg::S_TCHK;
        end
      end
      // a new pop sends out the held one as not final
      swtq_pkg::S_TCHK: begin
        if (rdata[71:8] <= tick_counter) begin
          if (woken != '0) begin
            strobe_next = 1'b1;
            status_next = swtq_pkg::ST_WOKEN;
            woken_id_next = pend_id;
            last_next = 1'b0;
          end
          pend_id_next = rdata[7:0];
          woken_next = woken + CW'(1);
          ptr_next = ptr + CW'(1);
          state_next = swtq_pkg::S_TRD;
        end else begin
          ptr_next = woken;
          strobe_next = 1'b1;
          last_next = 1'b1;
          if (woken == '0) begin
            status_next = swtq_pkg::ST_NONE;
            woken_id_next = '0;
            state_next = swtq_pkg::S_IDLE;
          end else begin
            status_next = swtq_pkg::ST_WOKEN;
            woken_id_next = pend_id;
            state_next = swtq_pkg::S_CRD;
          end
        end
      end
      // compact: move entry ptr down to ptr - woken
      swtq_pkg::S_CRD: begin
        if (ptr == entry_count) begin
          entry_count_next = entry_count - woken;
          state_next = swtq_pkg::S_IDLE;
        end else begin
          mre = 1'b1;
          maddr = IW'(ptr);
          state_next = swtq_pkg::S_CWR;
        end
      end
      swtq_pkg::S_CWR: begin
        mwe = 1'b1;
        maddr = IW'(ptr - woken);
        mwdata = rdata;
        ptr_next = ptr + CW'(1);
        state_next = swtq_pkg::S_CRD;
      end
      default: state_next = swtq_pkg::S_IDLE;
    endcase
  end

  `SWTQ_ASSERT_IMP(a_count_range, 1'b1, entry_count <= CW'(swtq_pkg::QUEUE_DEPTH), "count over depth")
  `SWTQ_ASSERT_NEXT(a_busy_after_start, start && !busy && !(func == swtq_pkg::FUNC_SLEEP && entry_count == CW'(swtq_pkg::QUEUE_DEPTH)), busy, "start not taken")
  `SWTQ_ASSERT_IMP(a_no_rw, 1'b1, !(mwe && mre), "memory read and write together")
endmodule

### tb/sv/tb.sv
// Testbench for the sorted wakeup timer queue: directed and random sleeps and ticks.
module tb;
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  woken_id;
    logic [63:0] tick_count;
    logic        last;
  } wake_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        func = 1'b0;
  logic [7:0]  sleeper_id = '0;
  logic [31:0] duration = '0;
  logic        busy, strobe, last;
  logic [1:0]  status;
  logic [7:0]  woken_id;
  logic [63:0] tick_count;

  // Shadow copy of the queue state
  logic [63:0] now_ticks;
  logic [63:0] q_wake[$];
  logic [7:0]  q_id[$];
  wake_result_t pending_results[$];

  int  idle_pct = 0;
  int  errors = 0;
  longint cycles = 0;

  sorted_wakeup_timer_queue u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .sleeper_id(sleeper_id), .duration(duration), .strobe(strobe),
    .status(status), .woken_id(woken_id), .tick_count(tick_count), .last(last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Predict the results of one item and queue them
  function automatic void predict_item(input logic f, input logic [7:0] id,
                                       input logic [31:0] dur);
    wake_result_t r;
    logic [63:0] wake;
    int pos;
    r = '0;
    if (f == swtq_pkg::FUNC_SLEEP) begin
      r.tick_count = now_ticks;
      r.last = 1'b1;
      if (q_wake.size() >= swtq_pkg::QUEUE_DEPTH) begin
        r.status = swtq_pkg::ST_FULL;
      end else begin
        wake = now_ticks + {32'd0, dur};
        pos = 0;
        while (pos < q_wake.size() && q_wake[pos] <= wake) pos++;
        q_wake.insert(pos, wake);
        q_id.insert(pos, id);
        r.status = swtq_pkg::ST_ACCEPTED;
      end
      pending_results.push_back(r);
    end else begin
      now_ticks = now_ticks + 64'd1;
      r.tick_count = now_ticks;
      if (q_wake.size() == 0 || q_wake[0] > now_ticks) begin
        r.status = swtq_pkg::ST_NONE;
        r.last = 1'b1;
        pending_results.push_back(r);
      end else begin
        while (q_wake.size() > 0 && q_wake[0] <= now_ticks) begin
          r.status = swtq_pkg::ST_WOKEN;
          r.woken_id = q_id[0];
          void'(q_wake.pop_front());
          void'(q_id.pop_front());
          r.last = (q_wake.size() == 0 || q_wake[0] > now_ticks);
          pending_results.push_back(r);
        end
      end
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    wake_result_t exp_r;
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: status %0d id %0d ticks %0d last %0d",
                 $time, status, woken_id, tick_count, last);
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.status) begin
          errors++;
          $display("%0t status: expected %0d actual %0d", $time, exp_r.status, status);
        end
        if (woken_id !== exp_r.woken_id) begin
          errors++;
          $display("%0t woken_id: expected %0d actual %0d", $time, exp_r.woken_id,
                   woken_id);
        end
        if (tick_count !== exp_r.tick_count) begin
          errors++;
          $display("%0t tick_count: expected %0d actual %0d", $time,
                   exp_r.tick_count, tick_count);
        end
        if (last !== exp_r.last) begin
          errors++;
          $display("%0t last: expected %0d actual %0d", $time, exp_r.last, last);
        end
      end
    end
  end

  // One transfer of a sleep or tick, with random idle cycles first;
  // start stays high until the next idle cycle or the next drain
  task automatic send_item(input logic f, input logic [7:0] id, input logic [31:0] dur);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    sleeper_id <= id;
    duration <= dur;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(f, id, dur);
  endtask

  task automatic send_sleep(input logic [7:0] id, input logic [31:0] dur);
    send_item(swtq_pkg::FUNC_SLEEP, id, dur);
  endtask

  task automatic send_tick();
    send_item(swtq_pkg::FUNC_TICK, 8'($urandom), $urandom);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic test_empty_ticks();
    send_tick();
    send_tick();
  endtask

  // Zero duration, equal wake times in arrival order, extreme fields
  task automatic test_ordering();
    send_sleep(8'h00, 32'd0);
    send_sleep(8'hFF, 32'd2);
    send_sleep(8'h11, 32'd0);
    send_sleep(8'hA5, 32'd2);
    send_sleep(8'h5A, 32'hFFFF_FFFF);
    send_sleep(8'h22, 32'd1);
    repeat (3) send_tick();
  endtask

  // Fill past depth, then wake the short sleepers with one tick
  task automatic test_full_queue();
    for (int i = 0; i < swtq_pkg::QUEUE_DEPTH; i++) send_sleep(i[7:0], 32'd1);
    send_sleep(8'h77, 32'd0);
    send_tick();
    drain();
  endtask

  // Random mix, mostly short durations so wakes happen often
  task automatic test_random(input int n, input int pct);
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1)) send_tick();
      else if ($urandom_range(9) == 0) send_sleep(8'($urandom), $urandom);
      else send_sleep(8'($urandom), $urandom_range(6));
    end
  endtask

  initial begin
    now_ticks = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_ticks();
    test_ordering();
    test_full_queue();
    test_random(100, 0);
    test_random(100, 78);
    drain();
    test_random(100, 31);
    test_random(100, 0);
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+src
src/swtq_pkg.sv
src/sorted_wakeup_timer_queue.sv
tb/sv/tb.sv
